@@ rtl/scdg_pkg.sv @@
// Shared types and constants for the spatial category density grid.
`default_nettype none

package scdg_pkg;

  // Item kinds.
  localparam logic [1:0] KIND_RECENTER = 2'd0;
  localparam logic [1:0] KIND_ADD      = 2'd1;
  localparam logic [1:0] KIND_QUERY    = 2'd2;

  // Category code that carries no category.
  localparam logic [1:0] CAT_INVALID = 2'd3;
  localparam int         NUM_CATS    = 3;

  // Configuration register indexes.
  localparam logic [1:0] CFG_CAP_PASSIVE = 2'd0;
  localparam logic [1:0] CFG_CAP_HOSTILE = 2'd1;
  localparam logic [1:0] CFG_CAP_AMBIENT = 2'd2;
  localparam logic [1:0] CFG_CELL_LIMIT  = 2'd3;

  // Configuration reset values.
  localparam logic [15:0] CAP_PASSIVE_RST = 16'd70;
  localparam logic [15:0] CAP_HOSTILE_RST = 16'd70;
  localparam logic [15:0] CAP_AMBIENT_RST = 16'd15;
  localparam logic [7:0]  CELL_LIMIT_RST  = 8'd4;

  // Saturation points.
  localparam logic [7:0]  CELL_SAT  = 8'd255;
  localparam logic [15:0] TOTAL_SAT = 16'hFFFF;

  // Width of a world cell coordinate: Q23.8 position with the fraction dropped.
  localparam int COORD_W  = 24;
  localparam int ORIGIN_W = 20;

  // Front to back queue.
  localparam int QDEPTH = 2;
  localparam int QPW    = 1;
  localparam int QCW    = 2;

  typedef struct packed {
    logic [1:0]         kind;
    logic [1:0]         cat;
    logic [COORD_W-1:0] cell_x;
    logic [COORD_W-1:0] cell_z;
  } item_t;

  typedef enum logic [1:0] {
    BK_CLEAR,
    BK_IDLE,
    BK_ACCESS
  } back_state_t;

endpackage

`default_nettype wire

@@ rtl/scdg_front.sv @@
// Front end: accepts items, drops those without effect and computes cell coordinates.
`default_nettype none

module scdg_front #(
  parameter int CELL_SIZE = 16
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [1:0]           in_kind,
  input  wire logic [1:0]           in_category,
  input  wire logic signed [31:0]   in_x_pos,
  input  wire logic signed [31:0]   in_z_pos,
  input  wire logic                 in_alive,
  input  wire logic                 hold,
  input  wire logic                 q_full,
  output logic                      q_push,
  output scdg_pkg::item_t           q_item
);
  import scdg_pkg::*;

  // floor(2^32 / CELL_SIZE); the estimate below is exact or one short.
  localparam logic [63:0] RECIP_W = (64'd1 << 32) / 64'(CELL_SIZE);
  localparam logic [32:0] RECIP   = RECIP_W[32:0];

  logic [31:0]  pos [2];
  logic         lane_neg [2];
  logic [22:0]  lane_u [2];
  logic [55:0]  lane_prod [2];

  logic         a_valid_r, a_valid_nxt;
  logic [1:0]   a_kind_r, a_cat_r;
  logic         a_neg_r [2];
  logic [22:0]  a_u_r [2];
  logic [22:0]  a_qe_r [2];

  logic [23:0]  lane_diff [2];
  logic [22:0]  lane_q [2];
  logic [23:0]  lane_cell [2];

  logic accept, keep;

  assign pos[0] = in_x_pos;
  assign pos[1] = in_z_pos;

  assign q_push   = a_valid_r && !q_full;
  assign in_stall = hold || (a_valid_r && q_full);
  assign accept   = in_valid && !in_stall;

  // Adds of dead items or of no category and kind three never reach the back end.
  assign keep = (in_kind == KIND_RECENTER) || (in_kind == KIND_QUERY) ||
                ((in_kind == KIND_ADD) && in_alive && (in_category != CAT_INVALID));

  // Floor by 256 is the arithmetic shift; a negative value is folded with ~
  // so that floor(a / C) = ~floor(~a / C) works on a non-negative numerator.
  always_comb begin
    for (int i = 0; i < 2; i++) begin
      lane_neg[i]  = pos[i][31];
      lane_u[i]    = lane_neg[i] ? ~pos[i][30:8] : pos[i][30:8];
      lane_prod[i] = 56'(lane_u[i]) * 56'(RECIP);
    end
  end

  always_comb begin
    for (int i = 0; i < 2; i++) begin
      lane_diff[i] = 24'(a_u_r[i]) - 24'(32'(a_qe_r[i]) * 32'(CELL_SIZE));
      lane_q[i]    = (lane_diff[i] >= 24'(CELL_SIZE)) ? a_qe_r[i] + 23'd1 : a_qe_r[i];
      lane_cell[i] = a_neg_r[i] ? ~{1'b0, lane_q[i]} : {1'b0, lane_q[i]};
    end
  end

  assign q_item.kind   = a_kind_r;
  assign q_item.cat    = a_cat_r;
  assign q_item.cell_x = lane_cell[0];
  assign q_item.cell_z = lane_cell[1];

  always_comb begin
    a_valid_nxt = a_valid_r;
    if (accept && keep) begin
      a_valid_nxt = 1'b1;
    end else if (q_push) begin
      a_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
    end else begin
      a_valid_r <= a_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && keep) begin
      a_kind_r <= in_kind;
      a_cat_r  <= in_category;
      for (int i = 0; i < 2; i++) begin
        a_neg_r[i] <= lane_neg[i];
        a_u_r[i]   <= lane_u[i];
        a_qe_r[i]  <= lane_prod[i][54:32];
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/scdg_queue.sv @@
// Two-entry queue of classified items between the front and back ends.
`default_nettype none

module scdg_queue (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       push,
  input  scdg_pkg::item_t push_item,
  output logic            full,
  input  wire logic       pop,
  output logic            not_empty,
  output scdg_pkg::item_t head
);
  import scdg_pkg::*;

  item_t            ent_r [QDEPTH];
  logic [QPW-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [QPW-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [QCW-1:0]   count_r, count_nxt;
  logic             do_push, do_pop;

  assign full      = (count_r == QCW'(QDEPTH));
  assign not_empty = (count_r != '0);
  assign head      = ent_r[rd_ptr_r];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    count_nxt  = count_r;
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

@@ rtl/scdg_back.sv @@
// Back end: totals, window origin, counter memory, configuration and result register.
`default_nettype none

module scdg_back #(
  parameter int GRID_DIM = 16
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        q_valid,
  input  scdg_pkg::item_t  q_item,
  output logic             q_pop,
  output logic             init_busy,
  input  wire logic        cfg_valid,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic             out_has_room,
  output logic             out_cell_ok
);
  import scdg_pkg::*;

  localparam int CELLS = GRID_DIM * GRID_DIM;
  localparam int NCNT  = NUM_CATS * CELLS;
  localparam int AW    = $clog2(NCNT);
  localparam int GW    = $clog2(GRID_DIM);
  localparam logic [AW-1:0] LAST_ADDR = AW'(NCNT - 1);

  back_state_t      state_r, state_nxt;
  logic [AW-1:0]    clr_cnt_r, clr_cnt_nxt;
  logic             init_r, init_nxt;
  logic [15:0]      totals_r [NUM_CATS];
  logic [15:0]      totals_nxt [NUM_CATS];
  logic [ORIGIN_W-1:0] origin_x_r, origin_x_nxt, origin_z_r, origin_z_nxt;
  logic [AW-1:0]    addr_r, addr_nxt;
  logic             is_query_r, is_query_nxt;
  logic             ok_en_r, ok_en_nxt;
  logic             room_r, room_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic             out_room_r, out_ok_r;
  logic [15:0]      caps_r [NUM_CATS];
  logic [7:0]       limit_r;

  logic [7:0]       mem [NCNT];
  logic [7:0]       rd_data_r;
  logic             rd_en, mem_we, out_load;
  logic [AW-1:0]    mem_waddr;
  logic [7:0]       mem_wdata;

  logic             cat_ok, win;
  logic [15:0]      cur_total, cur_cap;
  logic signed [COORD_W:0] gx, gz;
  logic [AW-1:0]    slot_addr;

  assign init_busy    = init_r;
  assign out_valid    = out_valid_r;
  assign out_has_room = out_room_r;
  assign out_cell_ok  = out_ok_r;

  // Window offsets are taken against the stored, wrapped origin.
  assign cat_ok = (q_item.cat != CAT_INVALID);
  assign gx = $signed({q_item.cell_x[COORD_W-1], q_item.cell_x}) -
              $signed((COORD_W+1)'($signed(origin_x_r)));
  assign gz = $signed({q_item.cell_z[COORD_W-1], q_item.cell_z}) -
              $signed((COORD_W+1)'($signed(origin_z_r)));
  assign win = !gx[COORD_W] && !gz[COORD_W] &&
               (gx < (COORD_W+1)'(GRID_DIM)) && (gz < (COORD_W+1)'(GRID_DIM));
  assign slot_addr = (cat_ok && win) ?
                     AW'(32'(q_item.cat) * 32'(CELLS) +
                         32'(gz[GW-1:0]) * 32'(GRID_DIM) + 32'(gx[GW-1:0])) : '0;

  always_comb begin
    cur_total = '0;
    cur_cap   = '0;
    for (int i = 0; i < NUM_CATS; i++) begin
      if (q_item.cat == 2'(i)) begin
        cur_total = totals_r[i];
        cur_cap   = caps_r[i];
      end
    end
  end

  always_comb begin
    state_nxt    = state_r;
    clr_cnt_nxt  = clr_cnt_r;
    init_nxt     = init_r;
    totals_nxt   = totals_r;
    origin_x_nxt = origin_x_r;
    origin_z_nxt = origin_z_r;
    addr_nxt     = addr_r;
    is_query_nxt = is_query_r;
    ok_en_nxt    = ok_en_r;
    room_nxt     = room_r;
    q_pop        = 1'b0;
    rd_en        = 1'b0;
    mem_we       = 1'b0;
    mem_waddr    = addr_r;
    mem_wdata    = (rd_data_r == CELL_SAT) ? CELL_SAT : rd_data_r + 8'd1;
    out_load     = 1'b0;
    unique case (state_r)
      BK_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_r;
        mem_wdata = '0;
        if (clr_cnt_r == LAST_ADDR) begin
          state_nxt = BK_IDLE;
          init_nxt  = 1'b0;
        end else begin
          clr_cnt_nxt = clr_cnt_r + 1'b1;
        end
      end
      BK_IDLE: begin
        if (q_valid) begin
          q_pop = 1'b1;
          priority if (q_item.kind == KIND_RECENTER) begin
            for (int i = 0; i < NUM_CATS; i++) begin
              totals_nxt[i] = '0;
            end
            origin_x_nxt = ORIGIN_W'(q_item.cell_x - COORD_W'(GRID_DIM / 2));
            origin_z_nxt = ORIGIN_W'(q_item.cell_z - COORD_W'(GRID_DIM / 2));
            clr_cnt_nxt  = '0;
            state_nxt    = BK_CLEAR;
          end else if (q_item.kind == KIND_ADD) begin
            for (int i = 0; i < NUM_CATS; i++) begin
              if (q_item.cat == 2'(i) && totals_r[i] != TOTAL_SAT) begin
                totals_nxt[i] = totals_r[i] + 16'd1;
              end
            end
            if (cat_ok && win) begin
              rd_en        = 1'b1;
              addr_nxt     = slot_addr;
              is_query_nxt = 1'b0;
              state_nxt    = BK_ACCESS;
            end
          end else if (q_item.kind == KIND_QUERY) begin
            rd_en        = 1'b1;
            addr_nxt     = slot_addr;
            room_nxt     = cat_ok && (cur_total < cur_cap);
            ok_en_nxt    = cat_ok && win;
            is_query_nxt = 1'b1;
            state_nxt    = BK_ACCESS;
          end else begin
            state_nxt = BK_IDLE;
          end
        end
      end
      BK_ACCESS: begin
        if (!is_query_r) begin
          mem_we    = 1'b1;
          state_nxt = BK_IDLE;
        end else if (!out_valid_r || !out_stall) begin
          out_load  = 1'b1;
          state_nxt = BK_IDLE;
        end
      end
      default: begin
        state_nxt = BK_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_CLEAR;
      clr_cnt_r   <= '0;
      init_r      <= 1'b1;
      out_valid_r <= 1'b0;
      origin_x_r  <= '0;
      origin_z_r  <= '0;
      for (int i = 0; i < NUM_CATS; i++) begin
        totals_r[i] <= '0;
      end
    end else begin
      state_r     <= state_nxt;
      clr_cnt_r   <= clr_cnt_nxt;
      init_r      <= init_nxt;
      out_valid_r <= out_valid_nxt;
      origin_x_r  <= origin_x_nxt;
      origin_z_r  <= origin_z_nxt;
      totals_r    <= totals_nxt;
    end
  end

  always_ff @(posedge clk) begin
    addr_r     <= addr_nxt;
    is_query_r <= is_query_nxt;
    ok_en_r    <= ok_en_nxt;
    room_r     <= room_nxt;
    if (out_load) begin
      out_room_r <= room_r;
      out_ok_r   <= ok_en_r && (rd_data_r < limit_r);
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      caps_r[0] <= CAP_PASSIVE_RST;
      caps_r[1] <= CAP_HOSTILE_RST;
      caps_r[2] <= CAP_AMBIENT_RST;
      limit_r   <= CELL_LIMIT_RST;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        CFG_CAP_PASSIVE: caps_r[0] <= cfg_data;
        CFG_CAP_HOSTILE: caps_r[1] <= cfg_data;
        CFG_CAP_AMBIENT: caps_r[2] <= cfg_data;
        CFG_CELL_LIMIT:  limit_r   <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Counter memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[slot_addr];
    end
  end

endmodule

`default_nettype wire

@@ rtl/spatial_category_density_grid_top.sv @@
// Spatial category density grid: per-category totals and a windowed grid of cell counters.
// An item passes the front end register (cell coordinate divide), then the two-entry queue.
// The back end reads the counter for an add or query, then writes it back or compares it;
// a compare waits while out_stall holds the last result. An add outside the window skips the
// counters; a recenter zeroes the totals, moves the window and clears every counter.
// After reset every counter is cleared while in_stall stays high; configuration is taken anytime.
`default_nettype none

module spatial_category_density_grid_top #(
  parameter int CELL_SIZE = 16,
  parameter int GRID_DIM  = 16
) (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  output logic                    in_stall,
  input  wire logic [1:0]         in_kind,
  input  wire logic [1:0]         in_category,
  input  wire logic signed [31:0] in_x_pos,
  input  wire logic signed [31:0] in_z_pos,
  input  wire logic               in_alive,
  output logic                    out_valid,
  input  wire logic               out_stall,
  output logic                    out_has_room,
  output logic                    out_cell_ok,
  input  wire logic               cfg_valid,
  output logic                    cfg_ready,
  input  wire logic [1:0]         cfg_index,
  input  wire logic [15:0]        cfg_data
);
  import scdg_pkg::*;

  item_t push_item, head;
  logic  push, full, pop, not_empty, init_busy;

  assign cfg_ready = 1'b1;

  scdg_front #(
    .CELL_SIZE (CELL_SIZE)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_kind     (in_kind),
    .in_category (in_category),
    .in_x_pos    (in_x_pos),
    .in_z_pos    (in_z_pos),
    .in_alive    (in_alive),
    .hold        (init_busy),
    .q_full      (full),
    .q_push      (push),
    .q_item      (push_item)
  );

  scdg_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (push_item),
    .full      (full),
    .pop       (pop),
    .not_empty (not_empty),
    .head      (head)
  );

  scdg_back #(
    .GRID_DIM (GRID_DIM)
  ) u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .q_valid      (not_empty),
    .q_item       (head),
    .q_pop        (pop),
    .init_busy    (init_busy),
    .cfg_valid    (cfg_valid),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_has_room (out_has_room),
    .out_cell_ok  (out_cell_ok)
  );

endmodule

`default_nettype wire

@@ tb/sv/tb_top.sv @@
// Self-checking testbench for the spatial category density grid top level.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import scdg_pkg::*;

  localparam int     CELL_SIZE = 16;
  localparam int     GRID_DIM  = 16;
  localparam int     GRID_AREA = GRID_DIM * GRID_DIM;
  localparam longint CELL_DIV  = 256 * CELL_SIZE;
  localparam longint CELL_MIN  = -(longint'(1) << 31) / CELL_DIV;
  localparam longint CELL_MAX  = ((longint'(1) << 31) / CELL_DIV) - 1;
  // The fourth kind code has no meaning and is dropped by the block.
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  // Cycles to drain up to four queued recenter clears once the last result is in.
  localparam int SETTLE_CYCLES = 4000;

  typedef struct packed {
    logic [1:0]         kind;
    logic [1:0]         cat;
    logic signed [31:0] x;
    logic signed [31:0] z;
    logic               alive;
  } grid_item_t;

  typedef struct {
    logic has_room;
    logic cell_ok;
    int   seq;
  } grid_result_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         in_kind = KIND_QUERY;
  logic [1:0]         in_category = 2'd0;
  logic signed [31:0] in_x_pos = '0;
  logic signed [31:0] in_z_pos = '0;
  logic               in_alive = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_has_room;
  logic               out_cell_ok;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = CFG_CAP_PASSIVE;
  logic [15:0]        cfg_data = '0;

  spatial_category_density_grid_top #(
    .CELL_SIZE(CELL_SIZE),
    .GRID_DIM (GRID_DIM)
  ) u_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_kind     (in_kind),
    .in_category (in_category),
    .in_x_pos    (in_x_pos),
    .in_z_pos    (in_z_pos),
    .in_alive    (in_alive),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_has_room(out_has_room),
    .out_cell_ok (out_cell_ok),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data)
  );

  // Shadow copy of the block's state and registers.
  logic [15:0] cat_cap     [0:NUM_CATS-1] = '{CAP_PASSIVE_RST, CAP_HOSTILE_RST, CAP_AMBIENT_RST};
  logic [7:0]  cell_lim    = CELL_LIMIT_RST;
  logic [15:0] cat_total   [0:NUM_CATS-1];
  logic [7:0]  grid_count  [0:NUM_CATS*GRID_AREA-1];
  logic [19:0] origin_x    = '0;
  logic [19:0] origin_z    = '0;

  grid_item_t   pending_items[$];
  grid_result_t expected_results[$];
  grid_item_t   cur_item;
  int           pushed_count   = 0;
  int           accepted_count = 0;
  int           mismatch_count = 0;
  int           send_idle_pct  = 0;
  int           recv_idle_pct  = 0;
  longint       aim_x = 0;
  longint       aim_z = 0;

  initial begin
    foreach (cat_total[i]) cat_total[i] = '0;
    foreach (grid_count[i]) grid_count[i] = '0;
  end

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
  end

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at %0t ns: %s", $time, msg);
    mismatch_count++;
  endtask

  // Floor division of a Q23.8 position by the cell size.
  function automatic longint world_to_cell(input logic signed [31:0] p);
    longint v;
    v = p;
    if (v >= 0) return v / CELL_DIV;
    return -((-v + CELL_DIV - 1) / CELL_DIV);
  endfunction

  function automatic int window_index(input logic signed [31:0] x, input logic signed [31:0] z);
    longint gx, gz;
    gx = world_to_cell(x) - longint'($signed(origin_x));
    gz = world_to_cell(z) - longint'($signed(origin_z));
    if (gx < 0 || gx >= GRID_DIM || gz < 0 || gz >= GRID_DIM) return -1;
    return int'(gz * GRID_DIM + gx);
  endfunction

  // Advances the shadow state by one transaction; returns one when a result is due.
  function automatic bit apply_item(input grid_item_t it, output grid_result_t res);
    int     idx;
    int     flat;
    longint org_cell;
    res.has_room = 1'b0;
    res.cell_ok  = 1'b0;
    res.seq      = 0;
    case (it.kind)
      KIND_RECENTER: begin
        foreach (cat_total[i]) cat_total[i] = '0;
        foreach (grid_count[i]) grid_count[i] = '0;
        org_cell = world_to_cell(it.x) - GRID_DIM / 2;
        origin_x = org_cell[19:0];
        org_cell = world_to_cell(it.z) - GRID_DIM / 2;
        origin_z = org_cell[19:0];
        return 1'b0;
      end
      KIND_ADD: begin
        if (it.alive && it.cat != CAT_INVALID) begin
          idx = window_index(it.x, it.z);
          if (cat_total[it.cat] != TOTAL_SAT) cat_total[it.cat]++;
          if (idx >= 0) begin
            flat = int'(it.cat) * GRID_AREA + idx;
            if (grid_count[flat] != CELL_SAT) grid_count[flat]++;
          end
        end
        return 1'b0;
      end
      KIND_QUERY: begin
        if (it.cat != CAT_INVALID) begin
          idx = window_index(it.x, it.z);
          res.has_room = cat_total[it.cat] < cat_cap[it.cat];
          if (idx >= 0) begin
            flat = int'(it.cat) * GRID_AREA + idx;
            res.cell_ok = grid_count[flat] < cell_lim;
          end
        end
        return 1'b1;
      end
      default: return 1'b0;
    endcase
  endfunction

  always @(posedge clk) begin : item_driver
    grid_result_t res;
    bit           take;
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      take = !in_valid;
      if (in_valid && !in_stall) begin
        if (apply_item(cur_item, res)) begin
          res.seq = accepted_count;
          expected_results.push_back(res);
        end
        accepted_count++;
        take = 1'b1;
      end
      if (take) begin
        if (pending_items.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_item = pending_items.pop_front();
          in_kind     <= cur_item.kind;
          in_category <= cur_item.cat;
          in_x_pos    <= cur_item.x;
          in_z_pos    <= cur_item.z;
          in_alive    <= cur_item.alive;
          in_valid    <= 1'b1;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin : result_monitor
    grid_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result arrived with no query waiting");
      end else begin
        want = expected_results.pop_front();
        if (out_has_room !== want.has_room)
          report_mismatch($sformatf("item %0d: has_room %b, expected %b",
                                    want.seq, out_has_room, want.has_room));
        if (out_cell_ok !== want.cell_ok)
          report_mismatch($sformatf("item %0d: cell_ok %b, expected %b",
                                    want.seq, out_cell_ok, want.cell_ok));
      end
    end
    out_stall <= rst_n && ($urandom_range(99) < recv_idle_pct);
  end

  task automatic push_item(input logic [1:0] kind, input logic [1:0] cat,
                           input logic signed [31:0] x, input logic signed [31:0] z,
                           input logic alive);
    grid_item_t it;
    it.kind  = kind;
    it.cat   = cat;
    it.x     = x;
    it.z     = z;
    it.alive = alive;
    pending_items.push_back(it);
    pushed_count++;
  endtask

  // A random position inside the given cell, clamped to the representable range.
  function automatic logic signed [31:0] pos_at(input longint c);
    longint cc, p;
    cc = (c < CELL_MIN) ? CELL_MIN : ((c > CELL_MAX) ? CELL_MAX : c);
    p = cc * CELL_DIV + longint'($urandom_range(CELL_DIV - 1));
    return p[31:0];
  endfunction

  // Offsets cluster around the window center so that cells fill up.
  function automatic longint pick_offset();
    int r;
    r = $urandom_range(99);
    if (r < 70) return longint'($urandom_range(2)) - 1;
    if (r < 95) return longint'($urandom_range(GRID_DIM - 1)) - GRID_DIM / 2;
    return longint'($urandom_range(GRID_DIM + 5)) - GRID_DIM / 2 - 3;
  endfunction

  function automatic longint pick_center();
    int r;
    r = $urandom_range(9);
    if (r < 7) return longint'($urandom_range(100)) - 50;
    if (r < 9) return longint'($urandom_range(CELL_MAX - CELL_MIN)) + CELL_MIN;
    if ($urandom_range(1)) return CELL_MAX - longint'($urandom_range(9));
    return CELL_MIN + longint'($urandom_range(9));
  endfunction

  task automatic add_random(input int count);
    int         r;
    logic [1:0] kind;
    logic [1:0] cat;
    logic       alive;
    repeat (count) begin
      r = $urandom_range(99);
      if (r < 8) begin
        push_item(2'($urandom_range(3)), 2'($urandom_range(3)), $urandom, $urandom,
                  1'($urandom_range(1)));
      end else if (r < 13) begin
        aim_x = pick_center();
        aim_z = pick_center();
        push_item(KIND_RECENTER, 2'($urandom_range(3)), pos_at(aim_x), pos_at(aim_z),
                  1'($urandom_range(1)));
      end else begin
        kind  = ($urandom_range(99) < 55) ? KIND_ADD : KIND_QUERY;
        cat   = ($urandom_range(9) == 0) ? CAT_INVALID : 2'($urandom_range(NUM_CATS - 1));
        alive = ($urandom_range(9) != 0);
        push_item(kind, cat, pos_at(aim_x + pick_offset()), pos_at(aim_z + pick_offset()),
                  alive);
      end
    end
  endtask

  task automatic add_directed();
    // Window at reset covers cells zero to fifteen.
    push_item(KIND_QUERY, 2'd0, 32'sd0, 32'sd0, 1'b0);
    push_item(KIND_QUERY, CAT_INVALID, 32'sd100, 32'sd100, 1'b1);
    push_item(KIND_UNUSED, 2'd1, -32'sd1, -32'sd1, 1'b1);
    push_item(KIND_ADD, 2'd0, 32'sd0, 32'sd0, 1'b0);
    push_item(KIND_ADD, CAT_INVALID, 32'sd0, 32'sd0, 1'b1);
    push_item(KIND_QUERY, 2'd0, 32'sd0, 32'sd0, 1'b1);
    // Negative positions round toward minus infinity.
    push_item(KIND_RECENTER, CAT_INVALID, -32'sd1, -32'sd4097, 1'b0);
    repeat (4) push_item(KIND_ADD, 2'd1, -32'sd1, -32'sd4097, 1'b1);
    push_item(KIND_QUERY, 2'd1, -32'sd4096, -32'sd8191, 1'b1);
    push_item(KIND_QUERY, 2'd1, 32'sd0, -32'sd4097, 1'b1);
    push_item(KIND_QUERY, 2'd2, -32'sd1, -32'sd4097, 1'b0);
    // Just past the window edge: counts in the total only.
    push_item(KIND_ADD, 2'd1, 32'sh0000_8000, 32'sd0, 1'b1);
    push_item(KIND_QUERY, 2'd1, 32'sh0000_8000, 32'sd0, 1'b1);
    // The origin wraps at the negative end of the coordinate range.
    push_item(KIND_RECENTER, 2'd0, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1);
    push_item(KIND_ADD, 2'd0, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b1);
    push_item(KIND_QUERY, 2'd0, 32'sh8000_0000, 32'sh7FFF_FFFF, 1'b0);
    push_item(KIND_RECENTER, 2'd2, 32'sh7FFF_FFFF, 32'sh8000_8000, 1'b0);
    push_item(KIND_ADD, 2'd2, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1);
    push_item(KIND_QUERY, 2'd2, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1);
    push_item(KIND_QUERY, 2'd0, 32'sh7FFF_FFFF, 32'sh8000_0000, 1'b1);
  endtask

  // Drives one cell to its ceiling.
  task automatic add_saturation();
    push_item(KIND_RECENTER, 2'd0, 32'sd0, 32'sd0, 1'b0);
    for (int i = 1; i <= 260; i++) begin
      push_item(KIND_ADD, 2'd0, pos_at(0), pos_at(0), 1'b1);
      if (i == 254 || i == 255 || i == 260)
        push_item(KIND_QUERY, 2'd0, pos_at(0), pos_at(0), 1'b1);
    end
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    if (idx == CFG_CELL_LIMIT) cell_lim = val[7:0];
    else cat_cap[idx] = val;
  endtask

  task automatic program_regs(input logic [15:0] cap_p, input logic [15:0] cap_h,
                              input logic [15:0] cap_a, input logic [7:0] limit);
    write_reg(CFG_CAP_PASSIVE, cap_p);
    write_reg(CFG_CAP_HOSTILE, cap_h);
    write_reg(CFG_CAP_AMBIENT, cap_a);
    write_reg(CFG_CELL_LIMIT, {8'd0, limit});
  endtask

  // Waits for every queued transaction and its result, then for a clear to finish.
  task automatic settle();
    int waited;
    do @(posedge clk); while (accepted_count != pushed_count);
    waited = 0;
    while (expected_results.size() != 0 && waited < 5000) begin
      @(posedge clk);
      waited++;
    end
    if (expected_results.size() != 0) begin
      report_mismatch($sformatf("%0d expected results never arrived",
                                expected_results.size()));
      expected_results.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    wait (rst_n);
    send_idle_pct = 16;
    recv_idle_pct = 58;
    add_directed();
    settle();
    program_regs(16'd20, 16'd5, 16'd40, 8'd2);
    add_random(200);
    settle();

    send_idle_pct = 58;
    recv_idle_pct = 16;
    program_regs(16'd0, 16'hFFFF, 16'd1, 8'd0);
    add_random(200);
    settle();
    program_regs(16'($urandom_range(100)), 16'($urandom_range(30)),
                 16'($urandom_range(60)), 8'd255);
    add_random(150);
    settle();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    program_regs(16'hFFFF, 16'd3, 16'd0, 8'd1);
    add_random(150);
    settle();
    program_regs(16'hFFFF, 16'd70, 16'd15, 8'd255);
    add_saturation();
    settle();

    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

  initial begin : watchdog
    #(30_000_000);
    $display("TEST FAILED");
    $finish;
  end

endmodule

@@ spatial_category_density_grid_top.f @@
rtl/scdg_pkg.sv
rtl/scdg_front.sv
rtl/scdg_queue.sv
rtl/scdg_back.sv
rtl/spatial_category_density_grid_top.sv
tb/sv/tb_top.sv
